/* rtl/lz_flag_bit_frame_decompressor_macros.svh */
// Assertion macros
`ifndef LZ_FLAG_BIT_FRAME_DECOMPRESSOR_MACROS_SVH
`define LZ_FLAG_BIT_FRAME_DECOMPRESSOR_MACROS_SVH
`define LZF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LZF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/lzfd_pkg.sv */
`timescale 1ns / 1ps
package lzfd_pkg;
   localparam int WinBits = 13;
   localparam int WinDepth = 1 << WinBits;
   localparam int PosBits = 20;
   localparam logic [20:0] MaxFrame = 21'd1048576;
   localparam logic [20:0] FrameReset = 21'd64000;
   localparam logic [2:0] ST_DATA = 3'd0;
   localparam logic [2:0] ST_END = 3'd1;
   localparam logic [2:0] ST_DONE = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   typedef enum logic [3:0] {
      PH_FLAG = 4'd0, PH_FLAG2 = 4'd1, PH_CBIT1 = 4'd2, PH_CBIT2 = 4'd3,
      PH_LIT = 4'd4, PH_WLO = 4'd5, PH_WHI = 4'd6, PH_XCNT = 4'd7, PH_SDIST = 4'd8
   } phase_type;
   typedef struct packed {
      logic [7:0]  in_byte;
      logic        chunk_end;
   } req_type;
   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  out_count;
      logic [19:0] out_offset;
      logic [2:0]  out_status;
      logic        run_last;
   } rsp_type;
endpackage

/* rtl/lzfd_if.sv */
`timescale 1ns / 1ps
interface lzfd_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;
   logic chunk_end;
   modport source (output valid, in_byte, chunk_end, input ready);
   modport sink (input valid, in_byte, chunk_end, output ready);
endinterface

interface lzfd_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] out_bytes;
   logic [3:0] out_count;
   logic [19:0] out_offset;
   logic [2:0] out_status;
   logic run_last;
   modport source (output valid, out_bytes, out_count, out_offset, out_status, run_last,
                   input ready);
   modport sink (input valid, out_bytes, out_count, out_offset, out_status, run_last,
                 output ready);
endinterface

interface lzfd_csr_if;
   logic valid;
   logic ready;
   logic [20:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* rtl/lzfd_ram.sv */
`timescale 1ns / 1ps
module lzfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/lz_flag_bit_frame_decompressor.sv */
`timescale 1ns / 1ps
// Operation: an item without a match passes through parse, up to four flag bits, flush,
// status and done, then back to idle; once decoding has stopped it skips parse and flag bits.
// A match of n bytes adds a copy phase: one pipelined history read per byte;
// an output stall at an eight-byte boundary holds the copy.
// Throughput: one item at a time; ready drops while an item is in work.
// Reset: synchronous, active high; clears the parser, the frame register to 64000.
module lz_flag_bit_frame_decompressor (
   input logic clock,
   input logic reset,
   lzfd_req_if.sink   req,
   lzfd_rsp_if.source rsp,
   lzfd_csr_if.sink   csr
);
   import lzfd_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_PARSE = 7'b0000010, S_COPY = 7'b0000100,
      S_FLUSH = 7'b0001000, S_STAT = 7'b0010000, S_DONE = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [20:0] frame_ff, frame_in;
   logic [20:0] wpos_ff, wpos_in;
   logic [31:0] flag_ff, flag_in;
   logic [5:0]  left_ff, left_in;
   logic [1:0]  fill_ff, fill_in;
   phase_type   ph_ff, ph_in;
   logic [15:0] pend_ff, pend_in;
   logic        stop_ff, stop_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  halt_ff, halt_in;
   logic [20:0] src_ff, src_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic        rdv_ff, rdv_in;
   logic [63:0] pack_ff, pack_in;
   logic [3:0]  pn_ff, pn_in;
   logic [19:0] poff_ff, poff_in;
   rsp_type     out_ff, out_in;
   logic        ovld_ff, ovld_in;
   logic        byp_ff, byp_in;
   logic [7:0]  wb_ff, wb_in;
   logic        we;
   logic [7:0]  wd;
   logic [WinBits-1:0] ra;
   logic [7:0]  rd;
   logic [7:0]  cb;
   logic [20:0] lim, mdist, srcv;
   logic [8:0]  mcnt;
   logic [21:0] send;
   logic        bit_v;

   lzfd_ram #(.Width(8), .Depth(WinDepth)) u_hist (
      .clock(clock), .wr_en(we), .wr_addr(wpos_ff[WinBits-1:0]), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   assign lim = (frame_ff > MaxFrame) ? MaxFrame : frame_ff;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = ovld_ff;
   assign rsp.out_bytes = out_ff.out_bytes;
   assign rsp.out_count = out_ff.out_count;
   assign rsp.out_offset = out_ff.out_offset;
   assign rsp.out_status = out_ff.out_status;
   assign rsp.run_last = out_ff.run_last;
   assign bit_v = flag_ff[31];
   assign cb = byp_ff ? wb_ff : rd;

   always_comb begin
      state_in = state_ff; frame_in = frame_ff; wpos_in = wpos_ff;
      flag_in = flag_ff; left_in = left_ff; fill_in = fill_ff; ph_in = ph_ff;
      pend_in = pend_ff; stop_in = stop_ff; byte_in = byte_ff; last_in = last_ff;
      halt_in = halt_ff; src_in = src_ff; cnt_in = cnt_ff; rdv_in = 1'b0;
      pack_in = pack_ff; pn_in = pn_ff; poff_in = poff_ff; out_in = out_ff;
      ovld_in = ovld_ff; we = 1'b0; wd = byte_ff; ra = src_ff[WinBits-1:0];
      mdist = 21'd0; mcnt = 9'd0; srcv = 21'd0; send = 22'd0;
      if (csr.valid) frame_in = csr.data;
      if (ovld_ff && rsp.ready) ovld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               byte_in = req.in_byte; last_in = req.chunk_end; halt_in = ST_DATA;
               pn_in = 4'd0; pack_in = 64'd0; poff_in = wpos_ff[19:0];
               state_in = stop_ff ? S_FLUSH : S_PARSE;
            end
         end
         S_PARSE: begin
            state_in = S_FLUSH;
            if (ph_ff == PH_WHI || ph_ff == PH_XCNT || ph_ff == PH_SDIST) begin
               if (ph_ff == PH_SDIST) begin
                  mdist = 21'h100 - {13'd0, byte_ff}; mcnt = {7'd0, pend_ff[1:0]} + 9'd2;
               end else begin
                  mdist = 21'h2000 - {8'd0, (ph_ff == PH_WHI) ? byte_ff : pend_ff[15:8],
                                      (ph_ff == PH_WHI) ? pend_ff[7:3] : pend_ff[7:3]};
                  mcnt = (ph_ff == PH_WHI) ? {6'd0, pend_ff[2:0]} + 9'd2
                                           : {1'b0, byte_ff} + 9'd2;
               end
               if (ph_ff == PH_WHI) pend_in = {byte_ff, pend_ff[7:0]};
               srcv = wpos_ff - mdist;
               send = {1'b0, srcv} + {13'd0, mcnt};
               if (ph_ff == PH_WHI && pend_ff[2:0] == 3'd0) begin
                  ph_in = PH_XCNT; state_in = S_OUT;
               end else if (ph_ff == PH_XCNT && byte_ff == 8'd0) begin
                  halt_in = ST_END; stop_in = 1'b1;
               end else if (mdist > wpos_ff || send >= {1'b0, lim}) begin
                  halt_in = ST_READ; stop_in = 1'b1;
               end else if ({1'b0, wpos_ff} + {13'd0, mcnt} >= {1'b0, lim}) begin
                  halt_in = ST_WRITE; stop_in = 1'b1;
               end else begin
                  src_in = srcv; cnt_in = mcnt; ph_in = PH_FLAG; state_in = S_COPY;
               end
            end else if (ph_ff == PH_LIT) begin
               if (wpos_ff >= lim) begin
                  halt_in = ST_WRITE; stop_in = 1'b1;
               end else begin
                  we = 1'b1; wd = byte_ff; wpos_in = wpos_ff + 21'd1;
                  pack_in = {56'd0, byte_ff}; pn_in = 4'd1; ph_in = PH_FLAG;
                  state_in = S_OUT;
               end
            end else if (ph_ff == PH_WLO) begin
               pend_in = {8'd0, byte_ff}; ph_in = PH_WHI; state_in = S_OUT;
            end else begin
               flag_in = flag_ff | ({24'd0, byte_ff} << {fill_ff, 3'd0});
               fill_in = fill_ff + 2'd1;
               if (fill_ff == 2'd3) left_in = 6'd32;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // run flag bits one per cycle
            if ((ph_ff == PH_FLAG || ph_ff == PH_FLAG2 || ph_ff == PH_CBIT1 ||
                 ph_ff == PH_CBIT2) && left_ff != 6'd0) begin
               flag_in = {flag_ff[30:0], 1'b0}; left_in = left_ff - 6'd1;
               case (ph_ff)
                  PH_FLAG: ph_in = bit_v ? PH_LIT : PH_FLAG2;
                  PH_FLAG2: begin
                     pend_in = 16'd0; ph_in = bit_v ? PH_WLO : PH_CBIT1;
                  end
                  PH_CBIT1: begin
                     pend_in = {14'd0, bit_v, 1'b0}; ph_in = PH_CBIT2;
                  end
                  default: begin
                     pend_in = pend_ff + {15'd0, bit_v}; ph_in = PH_SDIST;
                  end
               endcase
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_COPY: begin
            ra = src_ff[WinBits-1:0];
            if (rdv_ff) begin
               we = 1'b1; wd = cb; wpos_in = wpos_ff + 21'd1;
               pack_in = pack_ff | ({56'd0, cb} << {pn_ff[2:0], 3'd0});
               pn_in = pn_ff + 4'd1;
               cnt_in = cnt_ff - 9'd1;
            end
            if (rdv_ff && cnt_ff == 9'd1) begin
               state_in = S_OUT;
            end else if (pn_in == 4'd8) begin
               if (!ovld_in) begin
                  out_in = '{pack_in, pn_in, poff_ff, ST_DATA, 1'b0};
                  ovld_in = 1'b1; poff_in = poff_ff + {16'd0, pn_in};
                  pn_in = 4'd0; pack_in = 64'd0;
               end else begin
                  // hold: undo this step
                  we = 1'b0; wpos_in = wpos_ff; pack_in = pack_ff; pn_in = pn_ff;
                  cnt_in = cnt_ff; rdv_in = 1'b0; src_in = src_ff;
               end
            end
            if (state_in == S_COPY && !(we == 1'b0 && rdv_ff)) begin
               if (!rdv_ff || we) begin
                  rdv_in = 1'b1;
                  if (rdv_ff) src_in = src_ff + 21'd1;
                  ra = rdv_ff ? src_in[WinBits-1:0] : src_ff[WinBits-1:0];
               end
            end
         end
         S_FLUSH: begin
            if (!ovld_in) begin
               if (pn_ff != 4'd0) begin
                  out_in = '{pack_ff, pn_ff, poff_ff, ST_DATA,
                             (halt_ff == ST_DATA) && !last_ff};
                  ovld_in = 1'b1; pn_in = 4'd0; pack_in = 64'd0;
               end
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            if (!ovld_in) begin
               if (halt_ff != ST_DATA) begin
                  out_in = '{64'd0, 4'd0, wpos_ff[19:0], halt_ff, !last_ff};
                  ovld_in = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         default: begin
            if (!ovld_in) begin
               if (last_ff) begin
                  out_in = '{64'd0, 4'd0, wpos_ff[19:0], ST_DONE, 1'b1};
                  ovld_in = 1'b1;
                  wpos_in = 21'd0; flag_in = 32'd0; left_in = 6'd0; fill_in = 2'd0;
                  ph_in = PH_FLAG; pend_in = 16'd0; stop_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
      endcase
      byp_in = we && (ra == wpos_ff[WinBits-1:0]);
      wb_in = wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; frame_ff <= FrameReset;
         wpos_ff <= '0; flag_ff <= '0; left_ff <= '0; fill_ff <= '0;
         ph_ff <= PH_FLAG; pend_ff <= '0; stop_ff <= 1'b0; ovld_ff <= 1'b0;
         rdv_ff <= 1'b0; pn_ff <= '0; byp_ff <= 1'b0;
      end else begin
         state_ff <= state_in; frame_ff <= frame_in;
         wpos_ff <= wpos_in; flag_ff <= flag_in; left_ff <= left_in; fill_ff <= fill_in;
         ph_ff <= ph_in; pend_ff <= pend_in; stop_ff <= stop_in; ovld_ff <= ovld_in;
         rdv_ff <= rdv_in; pn_ff <= pn_in; byp_ff <= byp_in;
      end
      byte_ff <= byte_in; last_ff <= last_in; halt_ff <= halt_in; src_ff <= src_in;
      cnt_ff <= cnt_in; pack_ff <= pack_in; poff_ff <= poff_in; out_ff <= out_in;
      wb_ff <= wb_in;
   end
endmodule

/* rtl/lzfd_checker.sv */
`timescale 1ns / 1ps
`include "lz_flag_bit_frame_decompressor_macros.svh"
module lzfd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic req_valid,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] out_count,
   input logic [2:0] out_status
);
   import lzfd_pkg::*;

   `LZF_ASSERT_IMPL(a_cnt, clock, reset, rsp_valid && out_status == ST_DATA,
                    out_count != 4'd0 && out_count <= 4'd8)
   `LZF_ASSERT_IMPL(a_stat, clock, reset, rsp_valid && out_status != ST_DATA,
                    out_count == 4'd0)
   `LZF_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   `LZF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(out_count) && $stable(out_status))
endmodule

bind lz_flag_bit_frame_decompressor lzfd_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req.ready), .req_valid(req.valid),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .out_count(rsp.out_count),
   .out_status(rsp.out_status)
);
